// ===== src/speed_pulse_frequency_scaler_assert.svh =====
// assertion macros used by the rtl
`ifndef SPEED_PULSE_FREQUENCY_SCALER_ASSERT_SVH
`define SPEED_PULSE_FREQUENCY_SCALER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SPFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("spfs assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SPFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("spfs assertion failed");

`endif

// ===== src/spfs_pkg.sv =====
`default_nettype none

package spfs_pkg;

    localparam int COUNT_WIDTH_DEF = 24;
    localparam int SAMPLE_WIDTH    = 16;

    localparam logic [SAMPLE_WIDTH-1:0] WINDOW_RESET = 16'd100;
    localparam logic [SAMPLE_WIDTH-1:0] WINDOW_MIN   = 16'd1;

    // remainder of 4*period/5, tracked incrementally
    localparam logic [2:0] REM_ZERO = 3'd0;
    localparam logic [2:0] REM_MAX  = 3'd4;

    typedef struct packed {
        logic out_level;
        logic window_end;
    } t_result;

endpackage

`default_nettype wire

// ===== src/spfs_in_if.sv =====
`default_nettype none

interface spfs_in_if;
    logic valid;
    logic ready;
    logic sense_level;
    logic switch_level;

    modport source (output valid, output sense_level, output switch_level, input ready);
    modport sink   (input valid, input sense_level, input switch_level, output ready);
endinterface

`default_nettype wire

// ===== src/spfs_out_if.sv =====
`default_nettype none

interface spfs_out_if;
    logic valid;
    logic ready;
    logic out_level;
    logic window_end;

    modport source (output valid, output out_level, output window_end, input ready);
    modport sink   (input valid, input out_level, input window_end, output ready);
endinterface

`default_nettype wire

// ===== src/speed_pulse_frequency_scaler.sv =====
// speed pulse frequency scaler
// i_in (spfs_in_if sink): one beat per sensor pin sample, carrying the pin
//   level and the mode switch level; a beat is taken when valid and ready
//   are both high at a rising edge of i_clk
// o_out (spfs_out_if source): exactly one result beat per input beat, in
//   order: the open-drain output level after that sample and a flag that
//   the sample closed a window
// i_cfg_we / i_cfg_wdata: window length in samples, written while idle;
//   a length of zero behaves as one
// result: valid the cycle after its sample, unless held back in the skid register
// throughput: one sample per cycle while ready is high; all window, period and
//   half-period updates happen in the cycle the sample is taken, the 4/5 scaling
//   comes from a quotient/remainder pair kept in step with the period counter
// stall: results go to an output register backed by a skid register, so a
//   new beat is still taken while a result waits; ready drops only when both
//   hold a result, and rises again once the receiver takes one
// reset (i_rst_n, synchronous, active low): window length back to 100, all
//   counters cleared, output released high, both result registers empty
`default_nettype none

module speed_pulse_frequency_scaler #(
    parameter int COUNT_WIDTH = spfs_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [spfs_pkg::SAMPLE_WIDTH-1:0] i_cfg_wdata,
    spfs_in_if.sink                              i_in,
    spfs_out_if.source                           o_out
);
    import spfs_pkg::*;

    // width of 4*period, used only for checking the quotient tracking
    localparam int PROD_WIDTH = COUNT_WIDTH + 3;

    // configuration
    logic [SAMPLE_WIDTH-1:0] r_window_samples;

    // window and measurement state
    logic [SAMPLE_WIDTH-1:0] r_sample_count, n_sample_count;
    logic                    r_low_seen, n_low_seen;
    logic                    r_last_high, n_last_high;
    logic [COUNT_WIDTH-1:0]  r_period, n_period;
    logic [COUNT_WIDTH-1:0]  r_quot, n_quot;     // floor(4*period/5)
    logic [2:0]              r_rem, n_rem;       // 4*period mod 5
    logic [COUNT_WIDTH-1:0]  r_half_count, n_half_count;
    logic [COUNT_WIDTH-1:0]  r_half_period, n_half_period;
    logic                    r_edge, n_edge;
    logic                    r_miss, n_miss;     // one half period passed with no edge
    logic                    r_drive, n_drive;

    // result registers
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    // per-beat combinational terms
    logic                    accept, take;
    logic [SAMPLE_WIDTH-1:0] limit, cnt_inc;
    logic                    low_now, ended;
    logic                    period_sat, half_sat;
    logic [COUNT_WIDTH-1:0]  period_adv, half_adv;
    logic [COUNT_WIDTH-1:0]  quot_adv;
    logic [2:0]              rem_adv;
    logic                    latch, edge_now, event_hit;
    logic [COUNT_WIDTH-1:0]  period_latched;
    t_result                 result;

    assign accept = i_in.valid && i_in.ready;
    assign take   = r_out_valid && o_out.ready;

    // a zero length closes a window on every sample
    assign limit   = (r_window_samples == '0) ? WINDOW_MIN : r_window_samples;
    assign cnt_inc = r_sample_count + WINDOW_MIN;
    assign low_now = r_low_seen || !i_in.sense_level;
    assign ended   = (cnt_inc >= limit) || (cnt_inc == '0);

    // saturating window counters
    assign period_sat = &r_period;
    assign half_sat   = &r_half_count;
    assign period_adv = period_sat ? r_period : r_period + COUNT_WIDTH'(1);
    assign half_adv   = half_sat ? r_half_count : r_half_count + COUNT_WIDTH'(1);

    // 4*(period+1) = 5*quot + rem + 4, so the quotient steps when rem is nonzero
    always_comb begin
        if (period_sat) begin
            quot_adv = r_quot;
            rem_adv  = r_rem;
        end else if (r_rem == REM_ZERO) begin
            quot_adv = r_quot;
            rem_adv  = REM_MAX;
        end else begin
            quot_adv = r_quot + COUNT_WIDTH'(1);
            rem_adv  = r_rem - 3'd1;
        end
    end

    // high window followed by a low window latches a new half period
    assign latch          = low_now && r_last_high;
    assign period_latched = i_in.switch_level ? quot_adv : (period_adv >> 1);
    assign edge_now       = r_edge || latch;

    always_comb begin
        n_half_period = latch ? period_latched : r_half_period;
        event_hit     = half_adv >= n_half_period;
    end

    always_comb begin
        n_sample_count = cnt_inc;
        n_low_seen     = low_now;
        n_last_high    = r_last_high;
        n_period       = r_period;
        n_quot         = r_quot;
        n_rem          = r_rem;
        n_half_count   = r_half_count;
        n_edge         = r_edge;
        n_miss         = r_miss;
        n_drive        = r_drive;
        if (ended) begin
            n_sample_count = '0;
            n_low_seen     = 1'b0;
            n_last_high    = !low_now;
            n_period       = latch ? '0 : period_adv;
            n_quot         = latch ? '0 : quot_adv;
            n_rem          = latch ? REM_ZERO : rem_adv;
            n_half_count   = event_hit ? '0 : half_adv;
            n_edge         = event_hit ? 1'b0 : edge_now;
            if (event_hit) begin
                if (edge_now) begin
                    n_miss  = 1'b0;
                    n_drive = !r_drive;
                end else if (r_miss) begin
                    // second half period without an edge: release the line
                    n_miss  = 1'b1;
                    n_drive = 1'b1;
                end else begin
                    n_miss  = 1'b1;
                    n_drive = !r_drive;
                end
            end
        end
    end

    assign result.out_level  = n_drive;
    assign result.window_end = ended;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_samples <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window_samples <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= '0;
            r_low_seen     <= 1'b0;
            r_last_high    <= 1'b1;
            r_period       <= '0;
            r_quot         <= '0;
            r_rem          <= REM_ZERO;
            r_half_count   <= '0;
            r_half_period  <= '0;
            r_edge         <= 1'b0;
            r_miss         <= 1'b0;
            r_drive        <= 1'b1;
        end else if (accept) begin
            r_sample_count <= n_sample_count;
            r_low_seen     <= n_low_seen;
            if (ended) begin
                r_last_high   <= n_last_high;
                r_period      <= n_period;
                r_quot        <= n_quot;
                r_rem         <= n_rem;
                r_half_count  <= n_half_count;
                r_half_period <= n_half_period;
                r_edge        <= n_edge;
                r_miss        <= n_miss;
                r_drive       <= n_drive;
            end
        end
    end

    // output register with skid register behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_skid_valid) begin
            r_out <= r_skid;
        end else if (accept && (take || !r_out_valid)) begin
            r_out <= result;
        end
        if (accept && r_out_valid && !take) begin
            r_skid <= result;
        end
    end

    assign i_in.ready       = !r_skid_valid;
    assign o_out.valid      = r_out_valid;
    assign o_out.out_level  = r_out.out_level;
    assign o_out.window_end = r_out.window_end;

    `include "speed_pulse_frequency_scaler_assert.svh"

    `SPFS_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `SPFS_ASSERT_NEXT(a_accept_fills_out, i_clk, i_rst_n, accept, r_out_valid)
    `SPFS_ASSERT_NOW(a_rem_range, i_clk, i_rst_n, 1'b1, r_rem <= REM_MAX)
    `SPFS_ASSERT_NOW(a_quot_tracks_period, i_clk, i_rst_n, 1'b1,
        (PROD_WIDTH'(r_period) << 2) == (PROD_WIDTH'(r_quot) * PROD_WIDTH'(5) + PROD_WIDTH'(r_rem)))

endmodule

`default_nettype wire

// ===== tb/spfs_drive_checker.sv =====
`timescale 1ns / 1ps

// watches both channels and the window register, predicts each result beat
// and compares it with what the block sends
module spfs_drive_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [spfs_pkg::SAMPLE_WIDTH-1:0] i_cfg_wdata,
    spfs_in_if                                     in_mon,
    spfs_out_if                                    out_mon,
    output int                                     o_pending,
    output int                                     o_mismatches
);
    import spfs_pkg::*;

    localparam int CW = COUNT_WIDTH_DEF;
    localparam logic [CW-1:0] COUNT_MAX = '1;

    logic [SAMPLE_WIDTH-1:0] window_len;
    logic [SAMPLE_WIDTH-1:0] samples_in_window;
    logic                    low_in_window;
    logic                    prev_window_high;
    logic [CW-1:0]           period_windows;
    logic [CW-1:0]           half_windows;
    logic [CW-1:0]           half_target;
    logic                    pending_edge;
    logic [1:0]              missed_events;
    logic                    pin_out;

    t_result expected_levels[$];
    int      mismatches = 0;

    function automatic logic [CW-1:0] bump_sat(input logic [CW-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    task automatic close_window(input logic sw);
        logic [CW+3:0] scaled;
        period_windows = bump_sat(period_windows);
        half_windows   = bump_sat(half_windows);

        if (low_in_window) begin
            if (prev_window_high) begin
                // falling edge: latch the new half period
                pending_edge = 1'b1;
                if (sw) begin
                    scaled      = {4'b0, period_windows} << 3;
                    scaled      = scaled / (CW+4)'(10);
                    half_target = scaled[CW-1:0];
                end else begin
                    half_target = period_windows >> 1;
                end
                period_windows = '0;
            end
            prev_window_high = 1'b0;
        end else begin
            prev_window_high = 1'b1;
        end

        if (half_windows >= half_target) begin
            half_windows  = '0;
            missed_events = pending_edge ? 2'd0 : missed_events + 2'd1;
            pending_edge  = 1'b0;
            if (missed_events > 2'd1) begin
                missed_events = 2'd1;
                pin_out       = 1'b1;
            end else begin
                pin_out = ~pin_out;
            end
        end
    endtask

    task automatic predict_sample(input logic sense, input logic sw, output t_result res);
        logic [SAMPLE_WIDTH:0] limit;
        logic                  ended;
        limit = (window_len == '0) ? 17'd1 : {1'b0, window_len};
        ended = 1'b0;

        samples_in_window = samples_in_window + 1'b1;
        if (!sense)
            low_in_window = 1'b1;

        if ({1'b0, samples_in_window} >= limit || samples_in_window == '0) begin
            close_window(sw);
            samples_in_window = '0;
            low_in_window     = 1'b0;
            ended             = 1'b1;
        end

        res.out_level  = pin_out;
        res.window_end = ended;
    endtask

    always @(posedge i_clk) begin : track
        t_result got;
        t_result want;
        t_result res;
        if (!i_rst_n) begin
            window_len        = WINDOW_RESET;
            samples_in_window = '0;
            low_in_window     = 1'b0;
            prev_window_high  = 1'b1;
            period_windows    = '0;
            half_windows      = '0;
            half_target       = '0;
            pending_edge      = 1'b0;
            missed_events     = 2'd0;
            pin_out           = 1'b1;
            expected_levels.delete();
        end else begin
            // compare before pushing so a stray beat never matches this cycle's sample
            if (out_mon.valid && out_mon.ready) begin
                got.out_level  = out_mon.out_level;
                got.window_end = out_mon.window_end;
                if (expected_levels.size() == 0) begin
                    $error("result beat with no sample pending: out_level=%0b window_end=%0b",
                           got.out_level, got.window_end);
                    mismatches++;
                end else begin
                    want = expected_levels.pop_front();
                    if (got.out_level !== want.out_level) begin
                        $error("out_level: expected %0b, actual %0b",
                               want.out_level, got.out_level);
                        mismatches++;
                    end
                    if (got.window_end !== want.window_end) begin
                        $error("window_end: expected %0b, actual %0b",
                               want.window_end, got.window_end);
                        mismatches++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready) begin
                predict_sample(in_mon.sense_level, in_mon.switch_level, res);
                expected_levels.push_back(res);
            end
            if (i_cfg_we)
                window_len = i_cfg_wdata;
        end
        o_pending    <= expected_levels.size();
        o_mismatches <= mismatches;
    end

endmodule

// ===== tb/tb_speed_pulse_frequency_scaler.sv =====
`timescale 1ns / 1ps

// stimulus and verdict for the speed pulse frequency scaler; all prediction
// and comparison lives in spfs_drive_checker
module tb_speed_pulse_frequency_scaler;
    import spfs_pkg::*;

    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_SAMPLES = 750;
    localparam int SETTLE_CYCLES  = 4;       // a result may wait in the skid register before it shows
    localparam int CYCLE_LIMIT    = 200000;  // far above the slowest legal run

    // directed sense and switch sequences, indexed by sample number
    // falling edges, edges on consecutive samples, then the pin held high so the
    // output runs out of edges and is released
    localparam logic [19:0] DIR_SENSE  = 20'b1111_1111_1001_1001_0101;
    localparam logic [19:0] DIR_SWITCH = 20'b0101_1100_0011_1010_0110;

    // shape of the sensor pin within one phase
    typedef enum logic [1:0] {
        WAVE_SQUARE,   // clean square wave, the normal case
        WAVE_GLITCHY,  // square wave with random flipped samples
        WAVE_NOISE,    // random samples
        WAVE_HOLD      // pin stuck at one level
    } t_wave;

    // receiver stall modes
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [SAMPLE_WIDTH-1:0] cfg_wdata;

    int pending_results;
    int mismatch_total;
    int burst_left;
    int samples_sent;

    spfs_in_if  sample_if();
    spfs_out_if result_if();

    speed_pulse_frequency_scaler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (sample_if),
        .o_out       (result_if)
    );

    spfs_drive_checker drive_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .in_mon       (sample_if),
        .out_mon      (result_if),
        .o_pending    (pending_results),
        .o_mismatches (mismatch_total)
    );

    // 20 ns clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // result receiver: switches between stall modes at random intervals,
    // including long stretches where it never stalls
    initial begin : result_sink
        t_stall mode;
        int     left;
        int     tick;
        result_if.ready <= 1'b1;
        mode = STALL_NONE;
        left = 40;
        tick = 0;
        forever begin
            @(posedge clk);
            if (left == 0) begin
                mode = t_stall'($urandom_range(0, 3));
                left = $urandom_range(10, 80);
            end else begin
                left--;
            end
            tick++;
            case (mode)
                STALL_NONE:  result_if.ready <= 1'b1;
                STALL_LIGHT: result_if.ready <= ($urandom_range(0, 3) != 0);
                STALL_HEAVY: result_if.ready <= ($urandom_range(0, 2) == 0);
                default:     result_if.ready <= ((tick % 5) >= 2);
            endcase
        end
    end

    // watchdog: a hung handshake ends the run as a failure
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // one sample beat; the sender works in bursts, a gap with valid low
    // separates bursts so valid never drops and rises in one step
    task automatic send_sample(input logic sense, input logic sw);
        if (burst_left == 0) begin
            sample_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 20);
        end
        sample_if.valid        <= 1'b1;
        sample_if.sense_level  <= sense;
        sample_if.switch_level <= sw;
        do @(posedge clk); while (!sample_if.ready);
        burst_left--;
    endtask

    // stop sending and wait until every result beat has come back
    task automatic drain_results();
        sample_if.valid <= 1'b0;
        // let the checker count the last accepted sample first
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // window length write, only while the block is idle
    task automatic write_window(input logic [SAMPLE_WIDTH-1:0] len);
        cfg_we    <= 1'b1;
        cfg_wdata <= len;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        int          i;
        int          pick;
        int          window;
        int          eff;
        int          half;
        int          phase_len;
        t_wave       wave;
        logic        hold_level;
        logic        sw_fixed;
        logic        sw_random;
        logic        s;
        logic        w;

        sample_if.valid        <= 1'b0;
        sample_if.sense_level  <= 1'b1;
        sample_if.switch_level <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_wdata              <= '0;
        rst_n                  <= 1'b0;
        burst_left = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a few samples at the reset window length, every sense/switch pair
        for (i = 0; i < 4; i++)
            send_sample(i[0], i[1]);
        drain_results();

        // zero length acts as one; the window already holds four samples,
        // so this also lowers the length below the count mid-window
        write_window('0);
        for (i = 0; i < 20; i++)
            send_sample(DIR_SENSE[i], DIR_SWITCH[i]);
        drain_results();

        // random phases, each with its own window length and pin shape
        samples_sent = 0;
        while (samples_sent < RANDOM_SAMPLES) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                window = 0;
            else if (pick == 1)
                window = 65535;
            else if (pick == 2)
                window = 1;
            else if (pick <= 4)
                window = $urandom_range(100, 400);
            else
                window = $urandom_range(1, 12);
            write_window(window[SAMPLE_WIDTH-1:0]);

            // half period of the pin a few windows long so edges land
            // on window boundaries and the output gets to toggle
            eff  = (window == 0) ? 1 : window;
            half = eff * $urandom_range(1, 6);
            if (half > 200)
                half = 200;

            pick = $urandom_range(0, 19);
            if (pick < 11)
                wave = WAVE_SQUARE;
            else if (pick < 14)
                wave = WAVE_GLITCHY;
            else if (pick < 17)
                wave = WAVE_NOISE;
            else
                wave = WAVE_HOLD;

            hold_level = ($urandom_range(0, 3) != 0);
            sw_fixed   = 1'($urandom_range(0, 1));
            sw_random  = ($urandom_range(0, 3) == 0);
            phase_len  = $urandom_range(20, 70);

            for (i = 0; i < phase_len; i++) begin
                case (wave)
                    WAVE_SQUARE:  s = ((i / half) % 2) == 0;
                    WAVE_GLITCHY: s = (((i / half) % 2) == 0) ^ ($urandom_range(0, 7) == 0);
                    WAVE_NOISE:   s = 1'($urandom_range(0, 1));
                    default:      s = hold_level;
                endcase
                w = sw_random ? 1'($urandom_range(0, 1)) : sw_fixed;
                send_sample(s, w);
                samples_sent++;
            end
            drain_results();
        end

        if (mismatch_total == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/spfs_pkg.sv
src/spfs_in_if.sv
src/spfs_out_if.sv
src/speed_pulse_frequency_scaler.sv
tb/spfs_drive_checker.sv
tb/tb_speed_pulse_frequency_scaler.sv
